// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the PCM DAC RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define PDMF_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define PDMF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PDMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/pdmf_pkg.sv -----
// Types and constants for the PCM DAC with mute and fade.
package pdmf_pkg;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned LEVEL_W  = 15;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned ACC_W    = 41;  // exact weighted sum
  localparam int unsigned DIV_W    = 40;  // divisor shifted up by 8

  localparam logic [MODE_W-1:0] MODE_SAMPLE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ON     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MUTE   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TICK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_EMIT   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VOLUME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LEFT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_RIGHT = 2'd2;

  localparam logic [LEVEL_W-1:0] MAX_VOLUME_RST = 15'd8192;
  localparam logic [GAIN_W-1:0]  GAIN_RST       = 16'd16384;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX      = 15'h7FFF;
  localparam logic [1:0]         ACT_FRAMES     = 2'd2;
  localparam logic [3:0]         DIV_TOP        = 4'd8;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_MIX
  } ctrl_state_t;

  typedef enum logic [2:0] {
    MX_IDLE,
    MX_MUL1,
    MX_MUL2,
    MX_DIV,
    MX_VOL,
    MX_GAINL,
    MX_GAINR,
    MX_DONE
  } mix_state_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] older_sample;
    logic [SAMPLE_W-1:0] held_sample;
    logic [TIME_W-1:0]   d1;
    logic [TIME_W-1:0]   d2;
    logic [TIME_W-1:0]   total;
    logic                weighted;
  } mix_req_t;

endpackage

// ----- hw/rtl/pdmf_in_if.sv -----
// Input channel: command items into the DAC.
interface pdmf_in_if import pdmf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [SAMPLE_W-1:0] data;
  logic [SAMPLE_W-1:0] mask;
  logic [TIME_W-1:0]   now;
  logic                first_of_block;

  modport source (output valid, mode, data, mask, now, first_of_block, input ready);
  modport sink   (input valid, mode, data, mask, now, first_of_block, output ready);
endinterface

// ----- hw/rtl/pdmf_out_if.sv -----
// Result channel: output levels and realtime flag.
interface pdmf_out_if import pdmf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] left_level;
  logic [LEVEL_W-1:0] right_level;
  logic               realtime_render;

  modport source (output valid, left_level, right_level, realtime_render, input ready);
  modport sink   (input valid, left_level, right_level, realtime_render, output ready);
endinterface

// ----- hw/rtl/pdmf_cfg_if.sv -----
// Configuration write channel.
interface pdmf_cfg_if import pdmf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

// ----- hw/rtl/pdmf_mix.sv -----
// Level recompute: shared multiplier and restoring divider under a sequencer.
`include "assert_macros.svh"

module pdmf_mix import pdmf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  mix_req_t           req,
  input  logic [LEVEL_W-1:0] max_volume,
  input  logic [GAIN_W-1:0]  gain_left,
  input  logic [GAIN_W-1:0]  gain_right,
  output logic               done,
  output logic [LEVEL_W-1:0] level_left,
  output logic [LEVEL_W-1:0] level_right
);

  mix_state_t state_r, state_nxt;
  mix_req_t   req_r;
  logic [ACC_W-1:0]    acc_r;
  logic [DIV_W-1:0]    div_r;
  logic [3:0]          cnt_r;
  logic [SAMPLE_W-1:0] avg_r;
  logic [LEVEL_W-1:0]  vol_r;
  logic [LEVEL_W-1:0]  lvl_l_r, lvl_rt_r;

  logic [TIME_W-1:0]   mul_a;
  logic [GAIN_W-1:0]   mul_b;
  logic [47:0]         mul_p;
  logic                ge;
  logic [LEVEL_W-1:0]  gain_sat;

  // shared unit
  assign mul_p = {16'b0, mul_a} * {32'b0, mul_b};
  assign ge    = acc_r >= {1'b0, div_r};
  assign gain_sat = (|mul_p[30:29]) ? LEVEL_MAX : mul_p[28:14];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      MX_IDLE:  if (start) state_nxt = req.weighted ? MX_MUL1 : MX_VOL;
      MX_MUL1:  state_nxt = MX_MUL2;
      MX_MUL2:  state_nxt = MX_DIV;
      MX_DIV:   if (((cnt_r == DIV_TOP) && ge) || (cnt_r == 4'd0)) state_nxt = MX_VOL;
      MX_VOL:   state_nxt = MX_GAINL;
      MX_GAINL: state_nxt = MX_GAINR;
      MX_GAINR: state_nxt = MX_DONE;
      MX_DONE:  state_nxt = MX_IDLE;
      default:  state_nxt = MX_IDLE;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      MX_MUL1: begin
        mul_a = req_r.d1;
        mul_b = {8'b0, req_r.older_sample};
      end
      MX_MUL2: begin
        mul_a = req_r.d2;
        mul_b = {8'b0, req_r.held_sample};
      end
      MX_VOL: begin
        mul_a = {17'b0, max_volume};
        mul_b = {8'b0, avg_r};
      end
      MX_GAINL: begin
        mul_a = {17'b0, vol_r};
        mul_b = gain_left;
      end
      MX_GAINR: begin
        mul_a = {17'b0, vol_r};
        mul_b = gain_right;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign done        = (state_r == MX_DONE);
  assign level_left  = lvl_l_r;
  assign level_right = lvl_rt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MX_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      MX_IDLE: begin
        if (start) begin
          req_r <= req;
          avg_r <= req.held_sample;
        end
      end
      MX_MUL1: acc_r <= {1'b0, mul_p[39:0]};
      MX_MUL2: begin
        acc_r <= acc_r + {1'b0, mul_p[39:0]};
        div_r <= {req_r.total, 8'b0};
        cnt_r <= DIV_TOP;
        avg_r <= '0;
      end
      MX_DIV: begin
        if (cnt_r == DIV_TOP) begin
          // quotient beyond 255 saturates
          if (ge) avg_r <= 8'hFF;
        end else begin
          avg_r <= {avg_r[6:0], ge};
          if (ge) acc_r <= acc_r - {1'b0, div_r};
        end
        div_r <= {1'b0, div_r[DIV_W-1:1]};
        cnt_r <= cnt_r - 4'd1;
      end
      MX_VOL:   vol_r    <= mul_p[22:8];
      MX_GAINL: lvl_l_r  <= gain_sat;
      MX_GAINR: lvl_rt_r <= gain_sat;
      default: ;
    endcase
  end

  `PDMF_ASSERT_IMP(a_start_idle, clk, rst_n, start, state_r == MX_IDLE, "start while busy")
  `PDMF_ASSERT_IMP(a_div_cnt, clk, rst_n, state_r == MX_DIV, cnt_r <= DIV_TOP, "divider overrun")
  `PDMF_ASSERT_NEXT(a_done_idle, clk, rst_n, done, state_r == MX_IDLE, "no return after done")

endmodule

// ----- hw/rtl/pcm_dac_with_mute_fade_core.sv -----
// Top level of the 8-bit PCM DAC with activity detection, mute and fade.
// Result: registered after the transfer of a plain item; an active first-of-block emit
//   starts a recompute whose result is registered when it ends, time-weighted or not,
//   using the shared 32x16 multiplier and the nine-step restoring divider.
// Throughput: one plain item a cycle; input not ready in a recompute or an output stall.
// Reset: synchronous, active low; control state to defaults, output data not; no clearing pass.
`include "assert_macros.svh"

module pcm_dac_with_mute_fade_core import pdmf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  pdmf_in_if.sink    in_chan,
  pdmf_out_if.source out_chan,
  pdmf_cfg_if.sink   cfg_chan
);

  // configuration registers
  logic [LEVEL_W-1:0] max_vol_r;
  logic [GAIN_W-1:0]  gain_l_r, gain_rt_r;

  // DAC state
  logic [SAMPLE_W-1:0] held_r, held_nxt;
  logic [SAMPLE_W-1:0] prev_r, prev_nxt;
  logic [TIME_W-1:0]   mix_time_r, mix_time_nxt;
  logic [TIME_W-1:0]   chg_time_r, chg_time_nxt;
  logic [1:0]          act_r, act_nxt;
  logic                en_r, en_nxt;
  logic                mute_r, mute_nxt;
  logic                rt_r, rt_nxt;
  logic [LEVEL_W-1:0]  lvl_l_r, lvl_l_nxt;
  logic [LEVEL_W-1:0]  lvl_rt_r, lvl_rt_nxt;

  // result register
  logic               ov_r, ov_nxt;
  logic [LEVEL_W-1:0] ol_r, ol_nxt;
  logic [LEVEL_W-1:0] orr_r, orr_nxt;
  logic               ort_r, ort_nxt;

  ctrl_state_t state_r, state_nxt;

  logic                in_fire;
  logic                mix_start;
  logic                mix_done;
  logic [LEVEL_W-1:0]  mix_l, mix_r;
  logic [SAMPLE_W-1:0] val;
  logic                active;
  mix_req_t            req;

  assign val     = in_chan.data & in_chan.mask;
  assign active  = en_r && !mute_r && (act_r != 2'd0);
  assign in_fire = in_chan.valid && in_chan.ready;

  // request for the recompute, built from the pre-transfer state
  always_comb begin
    req.older_sample = prev_r;
    req.held_sample  = held_r;
    req.d1           = chg_time_r - mix_time_r;
    req.d2           = in_chan.now - chg_time_r;
    req.total        = in_chan.now - mix_time_r;
    req.weighted     = (chg_time_r > mix_time_r) && (in_chan.now != mix_time_r);
  end

  pdmf_mix u_mix (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (mix_start),
    .req         (req),
    .max_volume  (max_vol_r),
    .gain_left   (gain_l_r),
    .gain_right  (gain_rt_r),
    .done        (mix_done),
    .level_left  (mix_l),
    .level_right (mix_r)
  );

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (mix_start) state_nxt = ST_MIX;
      ST_MIX:  if (mix_done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer: outputs. A new item is taken once the result register drains.
  always_comb begin
    in_chan.ready = (state_r == ST_IDLE) && (!ov_r || out_chan.ready);
    mix_start     = in_fire && (in_chan.mode == MODE_EMIT) && active && in_chan.first_of_block;
  end

  assign cfg_chan.ready = 1'b1;

  // item handling
  always_comb begin
    held_nxt     = held_r;
    prev_nxt     = prev_r;
    mix_time_nxt = mix_time_r;
    chg_time_nxt = chg_time_r;
    act_nxt      = act_r;
    en_nxt       = en_r;
    mute_nxt     = mute_r;
    rt_nxt       = rt_r;
    lvl_l_nxt    = lvl_l_r;
    lvl_rt_nxt   = lvl_rt_r;

    if (in_fire) begin
      case (in_chan.mode)
        MODE_SAMPLE: begin
          // a changed sample re-arms two frames of activity
          if (held_r != val) begin
            act_nxt      = ACT_FRAMES;
            rt_nxt       = en_r && !mute_r;
            held_nxt     = val;
            chg_time_nxt = in_chan.now;
          end
        end
        MODE_ON: begin
          en_nxt = (val != '0);
          rt_nxt = (val != '0) && !mute_r && (act_r != 2'd0);
        end
        MODE_MUTE: begin
          mute_nxt = (val != '0);
          rt_nxt   = en_r && (val == '0) && (act_r != 2'd0);
        end
        MODE_TICK: begin
          if (act_r != 2'd0) begin
            act_nxt = act_r - 2'd1;
            if (act_r == 2'd1) rt_nxt = 1'b0;
          end
        end
        MODE_EMIT: begin
          if (active) begin
            if (in_chan.first_of_block) begin
              prev_nxt     = held_r;
              mix_time_nxt = in_chan.now;
            end
          end else begin
            // fade: levels step down by one per emitted sample
            if (lvl_l_r != '0) lvl_l_nxt = lvl_l_r - 15'd1;
            if (lvl_rt_r != '0) lvl_rt_nxt = lvl_rt_r - 15'd1;
          end
        end
        default: ;
      endcase
    end

    if (mix_done) begin
      lvl_l_nxt  = mix_l;
      lvl_rt_nxt = mix_r;
    end
  end

  // result register: loaded on a plain item or at the end of a recompute
  always_comb begin
    ov_nxt  = ov_r;
    ol_nxt  = ol_r;
    orr_nxt = orr_r;
    ort_nxt = ort_r;
    if (ov_r && out_chan.ready) ov_nxt = 1'b0;
    if (in_fire && !mix_start) begin
      ov_nxt  = 1'b1;
      ol_nxt  = lvl_l_r;
      orr_nxt = lvl_rt_r;
      ort_nxt = rt_nxt;
    end else if (mix_done) begin
      ov_nxt  = 1'b1;
      ol_nxt  = mix_l;
      orr_nxt = mix_r;
      ort_nxt = rt_r;
    end
  end

  assign out_chan.valid           = ov_r;
  assign out_chan.left_level      = ol_r;
  assign out_chan.right_level     = orr_r;
  assign out_chan.realtime_render = ort_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      max_vol_r  <= MAX_VOLUME_RST;
      gain_l_r   <= GAIN_RST;
      gain_rt_r  <= GAIN_RST;
      held_r     <= '0;
      prev_r     <= '0;
      mix_time_r <= '0;
      chg_time_r <= '0;
      act_r      <= '0;
      en_r       <= 1'b1;
      mute_r     <= 1'b0;
      rt_r       <= 1'b0;
      lvl_l_r    <= '0;
      lvl_rt_r   <= '0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      held_r     <= held_nxt;
      prev_r     <= prev_nxt;
      mix_time_r <= mix_time_nxt;
      chg_time_r <= chg_time_nxt;
      act_r      <= act_nxt;
      en_r       <= en_nxt;
      mute_r     <= mute_nxt;
      rt_r       <= rt_nxt;
      lvl_l_r    <= lvl_l_nxt;
      lvl_rt_r   <= lvl_rt_nxt;
      ov_r       <= ov_nxt;
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_chan.index)
          CFG_MAX_VOLUME: max_vol_r <= cfg_chan.wdata[LEVEL_W-1:0];
          CFG_GAIN_LEFT:  gain_l_r  <= cfg_chan.wdata;
          CFG_GAIN_RIGHT: gain_rt_r <= cfg_chan.wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    ol_r  <= ol_nxt;
    orr_r <= orr_nxt;
    ort_r <= ort_nxt;
  end

  `PDMF_ASSERT_IMP(a_busy_stall, clk, rst_n, state_r == ST_MIX, !in_chan.ready, "ready during recompute")
  `PDMF_ASSERT_IMP(a_done_mix, clk, rst_n, mix_done, state_r == ST_MIX, "stray recompute done")
  `PDMF_ASSERT_ALWAYS(a_rt_flag, clk, rst_n, rt_r == active, "realtime flag out of step")

endmodule
